>>> hdl/esd_pkg.sv
// shared types, codes and constants for the energy stiffness degradation block
// no dependencies
package esd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ENERGY_W      = 32;
    localparam int EXPO_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        FUNC_SET_TRIAL = 2'd0,
        FUNC_COMMIT    = 2'd1,
        FUNC_REVERT    = 2'd2,
        FUNC_START     = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_EXPONENT  = 2'd1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_LOG,
        ST_MUL_Y,
        ST_EXP,
        ST_MUL_T,
        ST_SHIFT,
        ST_DONE
    } t_state;

    // 2^(2^-k) for k = 1..16 in Q30
    localparam logic [31:0] EXP2_TAB [16] = '{
        32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
        32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033,
        32'd1075196443, 32'd1074468888, 32'd1074105294, 32'd1073923544,
        32'd1073832680, 32'd1073787251, 32'd1073764537, 32'd1073753181
    };

endpackage

>>> hdl/esd_if.sv
// valid/ready channel interfaces for input items, results and config writes
// depends on esd_pkg
interface esd_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     func;
    logic [esd_pkg::ENERGY_W-1:0]   energy_value;
    modport source (output valid, func, energy_value, input ready);
    modport sink   (input valid, func, energy_value, output ready);
endinterface

interface esd_out_if;
    logic                           valid;
    logic                           ready;
    logic [esd_pkg::ENERGY_W-1:0]   factor;
    logic                           capacity_reached;
    logic                           saturated;
    modport source (output valid, factor, capacity_reached, saturated, input ready);
    modport sink   (input valid, factor, capacity_reached, saturated, output ready);
endinterface

interface esd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [esd_pkg::CFG_IDX_W-1:0]  index;
    logic [31:0]                    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/energy_stiffness_degradation.sv
// energy based stiffness degradation factor, trial/commit state
// depends on esd_pkg and esd_if; one shared 32x32 multiplier under a sequencer
// sequencing: commit, revert, restart and the capacity / zero excursion cases go
//   straight to the output step; a full set trial runs two normalize walks,
//   2x16 log squarings, 16 exp steps, 2 more multiplies, a shift and the output step
// throughput: one item at a time, next accepted once the result is registered
// reset: synchronous active low, factors to one, sums and excursion to zero
module energy_stiffness_degradation #(
    parameter int FRAC_BITS = esd_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    esd_in_if.sink     i_in,
    esd_out_if.source  o_out,
    esd_cfg_if.sink    i_cfg
);
    import esd_pkg::*;

    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    t_state       r_state, n_state;
    logic [31:0]  r_thr, n_thr;
    logic [15:0]  r_expo, n_expo;
    logic [31:0]  r_texc, n_texc;
    logic [31:0]  r_tsum, n_tsum;
    logic [31:0]  r_csum, n_csum;
    logic [31:0]  r_tf, n_tf;
    logic [31:0]  r_cf, n_cf;
    logic [31:0]  r_m, n_m;
    logic [4:0]   r_p, n_p;
    logic [3:0]   r_cnt, n_cnt;
    logic [20:0]  r_r, n_r;
    logic [20:0]  r_le, n_le;
    logic         r_second, n_second;
    logic [20:0]  r_diff, n_diff;
    logic         r_neg, n_neg;
    logic [15:0]  r_fp, n_fp;
    logic signed [10:0] r_s, n_s;
    logic [62:0]  r_t, n_t;
    logic         r_sat, n_sat;
    logic [31:0]  r_res, n_res;
    logic         r_ovalid, n_ovalid;
    logic [31:0]  r_ofactor, n_ofactor;
    logic         r_ocap, n_ocap;
    logic         r_osat, n_osat;

    logic [31:0]  mul_a, mul_b;
    logic [63:0]  prod;
    logic         in_xfer;
    logic [32:0]  sum33;
    logic [31:0]  tsum_new;
    logic [32:0]  dbl;
    logic [31:0]  sq;
    logic [20:0]  ld;
    logic [24:0]  ymag;
    logic [15:0]  fpm;
    logic signed [10:0] ip;
    logic [10:0]  shr;
    logic [63:0]  term;
    logic [64:0]  total;
    logic         shl_sat;
    logic [5:0]   shl;

    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign prod        = 64'(mul_a) * 64'(mul_b);

    assign o_out.valid            = r_ovalid;
    assign o_out.factor           = r_ofactor;
    assign o_out.capacity_reached = r_ocap;
    assign o_out.saturated        = r_osat;

    always_comb begin
        unique case (r_state)
            ST_LOG:   begin mul_a = r_m;                mul_b = r_m;              end
            ST_MUL_Y: begin mul_a = {11'd0, r_diff};    mul_b = {16'd0, r_expo};  end
            ST_EXP:   begin mul_a = r_m;                mul_b = EXP2_TAB[r_cnt];  end
            ST_MUL_T: begin mul_a = r_m;                mul_b = r_cf;             end
            default:  begin mul_a = '0;                 mul_b = '0;               end
        endcase
    end

    always_comb begin
        n_state = r_state;  n_thr = r_thr;    n_expo = r_expo;  n_texc = r_texc;
        n_tsum = r_tsum;    n_csum = r_csum;  n_tf = r_tf;      n_cf = r_cf;
        n_m = r_m;          n_p = r_p;        n_cnt = r_cnt;    n_r = r_r;
        n_le = r_le;        n_second = r_second; n_diff = r_diff; n_neg = r_neg;
        n_fp = r_fp;        n_s = r_s;        n_t = r_t;        n_sat = r_sat;
        n_res = r_res;      n_ovalid = r_ovalid; n_ofactor = r_ofactor;
        n_ocap = r_ocap;    n_osat = r_osat;

        sum33    = 33'(r_csum) + 33'(i_in.energy_value);
        tsum_new = sum33[32] ? MAX32 : sum33[31:0];
        dbl      = 33'(r_cf) + 33'(r_cf);
        sq       = prod[61:30];
        ld       = {r_r[20:16], r_r[14:0], sq[31]};
        ymag     = prod[36:12];
        fpm      = ymag[15:0];
        ip       = '0;
        shr      = '0;
        shl      = '0;
        term     = '0;
        total    = '0;
        shl_sat  = 1'b0;

        if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_THRESHOLD: n_thr  = i_cfg.data;
                REG_EXPONENT:  n_expo = i_cfg.data[15:0];
                default: ;
            endcase
        end

        if (r_ovalid && o_out.ready) n_ovalid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_sat   = 1'b0;
                    n_state = ST_DONE;
                    unique case (t_func'(i_in.func))
                        FUNC_SET_TRIAL: begin
                            n_texc = i_in.energy_value;
                            n_tsum = tsum_new;
                            n_sat  = sum33[32];
                            if (tsum_new >= r_thr) begin
                                n_tf  = r_cf;
                                n_res = r_cf;
                            end else if (i_in.energy_value == '0) begin
                                if (r_expo == '0) begin
                                    n_tf  = dbl[32] ? MAX32 : dbl[31:0];
                                    n_sat = dbl[32];
                                end else begin
                                    n_tf = r_cf;
                                end
                                n_res = n_tf;
                            end else begin
                                n_m      = i_in.energy_value;
                                n_p      = 5'd31;
                                n_second = 1'b0;
                                n_state  = ST_NORM;
                            end
                        end
                        FUNC_COMMIT: begin
                            n_cf   = r_tf;
                            n_csum = r_tsum;
                            n_res  = r_tf;
                        end
                        FUNC_REVERT: begin
                            n_tf   = r_cf;
                            n_tsum = r_csum;
                            n_res  = r_cf;
                        end
                        FUNC_START: begin
                            n_cf   = ONE;
                            n_tf   = ONE;
                            n_csum = '0;
                            n_tsum = '0;
                            n_texc = '0;
                            n_res  = ONE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_NORM: begin
                if (r_m[31]) begin
                    n_m     = {1'b0, r_m[31:1]};
                    n_r     = {r_p, 16'd0};
                    n_cnt   = 4'd15;
                    n_state = ST_LOG;
                end else begin
                    n_m = {r_m[30:0], 1'b0};
                    n_p = r_p - 5'd1;
                end
            end
            ST_LOG: begin
                n_r = ld;
                n_m = sq[31] ? {1'b0, sq[31:1]} : sq;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == '0) begin
                    if (!r_second) begin
                        n_le     = ld;
                        n_m      = r_thr - r_tsum;
                        n_p      = 5'd31;
                        n_second = 1'b1;
                        n_state  = ST_NORM;
                    end else begin
                        n_neg   = ld > r_le;
                        n_diff  = (ld > r_le) ? (ld - r_le) : (r_le - ld);
                        n_state = ST_MUL_Y;
                    end
                end
            end
            ST_MUL_Y: begin
                if (r_neg) begin
                    ip   = -$signed({2'b00, ymag[24:16]}) - ((fpm != '0) ? 11'sd1 : 11'sd0);
                    n_fp = -fpm;
                end else begin
                    ip   = $signed({2'b00, ymag[24:16]});
                    n_fp = fpm;
                end
                n_s     = ip - 11'sd30;
                n_m     = 32'd1 << 30;
                n_cnt   = '0;
                n_state = ST_EXP;
            end
            ST_EXP: begin
                if (r_fp[4'd15 - r_cnt]) n_m = prod[61:30];
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) n_state = ST_MUL_T;
            end
            ST_MUL_T: begin
                n_t     = prod[62:0];
                n_state = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (r_s < 0) begin
                    shr  = 11'(-r_s);
                    term = (shr >= 11'd64) ? 64'd0 : (64'(r_t) >> shr[5:0]);
                end else if (r_t == '0) begin
                    term = '0;
                end else if (r_s >= 11'sd32) begin
                    shl_sat = 1'b1;
                end else begin
                    shl = 6'(r_s[4:0]);
                    if ((64'(r_t) >> (6'd32 - shl)) != '0) shl_sat = 1'b1;
                    else term = 64'(r_t) << shl;
                end
                total = 65'(r_cf) + 65'(term);
                if (shl_sat || total > 65'(MAX32)) begin
                    n_tf  = MAX32;
                    n_sat = 1'b1;
                end else begin
                    n_tf = total[31:0];
                end
                n_res   = n_tf;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid  = 1'b1;
                    n_ofactor = r_res;
                    n_ocap    = r_tsum >= r_thr;
                    n_osat    = r_sat;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_thr    <= '0;
            r_expo   <= 16'd4096;
            r_texc   <= '0;
            r_tsum   <= '0;
            r_csum   <= '0;
            r_tf     <= ONE;
            r_cf     <= ONE;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_thr    <= n_thr;
            r_expo   <= n_expo;
            r_texc   <= n_texc;
            r_tsum   <= n_tsum;
            r_csum   <= n_csum;
            r_tf     <= n_tf;
            r_cf     <= n_cf;
        end
        r_m       <= n_m;
        r_p       <= n_p;
        r_cnt     <= n_cnt;
        r_r       <= n_r;
        r_le      <= n_le;
        r_second  <= n_second;
        r_diff    <= n_diff;
        r_neg     <= n_neg;
        r_fp      <= n_fp;
        r_s       <= n_s;
        r_t       <= n_t;
        r_sat     <= n_sat;
        r_res     <= n_res;
        r_ofactor <= n_ofactor;
        r_ocap    <= n_ocap;
        r_osat    <= n_osat;
    end

endmodule

>>> hdl/esd_checker.sv
// port level checks for energy_stiffness_degradation
// depends on esd_pkg; attached to the top level by the bind below
module esd_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_factor,
    input logic        i_cap,
    input logic        i_sat
);
    import esd_pkg::*;

    // one item in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while busy");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a clamp shows either as a full sum or a maxed factor
    a_sat_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sat |-> i_cap || (i_factor == MAX32))
        else $error("saturated without cause");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_factor))
        else $error("stalled result changed");

endmodule

bind energy_stiffness_degradation esd_props u_esd_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_factor    (o_out.factor),
    .i_cap       (o_out.capacity_reached),
    .i_sat       (o_out.saturated)
);
